[rtl/btc_pkg.sv]
package btc_pkg;

  // ASCII codes the converter reacts to
  localparam logic [7:0] C_SPACE = 8'h20;
  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_LF    = 8'h0A;
  localparam logic [7:0] C_CR    = 8'h0D;
  localparam logic [7:0] C_BS    = 8'h08;

  localparam int STOP_W      = 12;
  localparam int NUM_STOPS   = 6;
  localparam int MAX_STOPS   = 6;
  localparam int DEFAULT_TAB = 8;
  localparam int MAX_PENDING = 63;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_ALL_MODE = 3'd0;
  localparam logic [2:0] REG_STOP_CNT = 3'd1;
  localparam logic [2:0] REG_STOP_A   = 3'd2;

  typedef logic [NUM_STOPS-1:0][STOP_W-1:0] stop_vec_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       overflow;
  } res_t;

endpackage

[rtl/btc_in_if.sv]
interface btc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

[rtl/btc_out_if.sv]
interface btc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       overflow;

  modport source (output valid, output out_byte, output last, output overflow, input ready);
  modport sink   (input valid, input out_byte, input last, input overflow, output ready);
endinterface

[rtl/blank_run_to_tab_converter.sv]
// Blank-run to tab converter. Text bytes enter on in_ch, one item per cycle at best;
// blanks eligible for conversion are absorbed into a pending run and produce nothing.
// A byte that ends a run, or an end-of-source item, first sets up the run walk, which
// then emits the run's tabs and spaces in turn; a text byte then follows on its own.
// Results leave through a two-entry output buffer, so input keeps flowing while one
// result waits. Every configuration write starts a restoring remainder pass that
// rebuilds the repeating tab stops after the column and after the pending run's start,
// one column bit per cycle; input items wait during that pass.
module blank_run_to_tab_converter #(
  parameter int MAX_COLUMN = 4095
) (
  input  logic                          clk,
  input  logic                          rst_n,
  btc_in_if.sink                        in_ch,
  btc_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btc_pkg::APB_AW-1:0]    paddr,
  input  logic [btc_pkg::APB_DW-1:0]    pwdata,
  output logic [btc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import btc_pkg::*;

  localparam int CW   = $clog2(MAX_COLUMN + 1);
  localparam int TW   = ((CW > STOP_W) ? CW : STOP_W) + 1;
  localparam int CNTW = $clog2(CW);
  localparam int SIW  = $clog2(NUM_STOPS);
  localparam logic [TW-1:0] MAXC_T = TW'(MAX_COLUMN);
  localparam logic [CW-1:0] MAXC   = CW'(MAX_COLUMN);
  localparam logic [TW-1:0] MAXP_T = TW'(MAX_PENDING);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_WALK = 3'b010,
    ST_CALC = 3'b100
  } state_t;

  // configuration
  logic            all_mode_r;
  logic [2:0]      stop_cnt_r;
  stop_vec_t       stops_r;
  logic            cfg_wr;
  logic [2:0]      cfg_idx;
  logic [SIW-1:0]  stop_sel;

  // line state
  state_t          st_r, st_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [CW-1:0]   rs_r, rs_nxt;
  logic            pend_r, pend_nxt;
  logic            seen_r, seen_nxt;
  logic            ovf_r, ovf_nxt;
  logic [TW-1:0]   rept_r, rept_nxt;         // repeating next stop after col_r
  logic [TW-1:0]   run_rept_r, run_rept_nxt; // same, taken at run start
  logic [CW-1:0]   walk_c_r, walk_c_nxt;
  logic [TW-1:0]   walk_t_r, walk_t_nxt;
  logic [CNTW-1:0] div_cnt_r, div_cnt_nxt;
  logic [STOP_W:0] rem_r, rem_nxt;
  logic [STOP_W:0] rrem_r, rrem_nxt;         // remainder for the run start

  // input register
  logic            in_vld_r;
  logic            in_type_r;
  logic [7:0]      in_byte_r;
  logic            consume;

  // output side
  logic            push;
  res_t            push_d;
  res_t            head;
  logic            room;

  // derived
  logic [STOP_W-1:0] iv;
  logic [TW-1:0]     iv_t;
  logic              list_mode;
  logic [2:0]        n_stops;
  logic [TW-1:0]     col_e, t_col, t_walk, c_walk_e, c_step_e;
  logic              is_tab, walk_done;
  logic              is_blank, elig, run_busy, ovf_item, is_eol, is_bs;
  logic [TW-1:0]     rs_e, nc0, nc1, nc2;
  logic              nc_ovf1, nc_ovf2;
  logic [STOP_W:0]   rem_sh, rem_step;
  logic [STOP_W:0]   rrem_sh, rrem_step;

  function automatic logic [TW-1:0] list_next(input logic [CW-1:0] c,
                                              input logic [2:0] n,
                                              input stop_vec_t s);
    logic [TW-1:0] res;
    res = TW'(c);
    // descending so the earliest qualifying entry wins
    for (int i = NUM_STOPS - 1; i >= 0; i--) begin
      if (3'(i) < n && TW'(s[i]) > TW'(c)) begin
        res = TW'(s[i]);
      end
    end
    return res;
  endfunction

  // ---------------- configuration port ----------------
  assign pready   = 1'b1;
  assign cfg_idx  = paddr[4:2];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign stop_sel = SIW'(cfg_idx - REG_STOP_A);

  always_comb begin
    unique case (cfg_idx)
      REG_ALL_MODE: prdata = APB_DW'(all_mode_r);
      REG_STOP_CNT: prdata = APB_DW'(stop_cnt_r);
      default:      prdata = APB_DW'(stops_r[stop_sel]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_mode_r <= 1'b0;
      stop_cnt_r <= 3'd0;
      for (int i = 0; i < NUM_STOPS; i++) begin
        stops_r[i] <= STOP_W'(8 * (i + 1));
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALL_MODE: all_mode_r <= pwdata[0];
        REG_STOP_CNT: stop_cnt_r <= pwdata[2:0];
        default:      stops_r[stop_sel] <= pwdata[STOP_W-1:0];
      endcase
    end
  end

  // ---------------- tab stop helpers ----------------
  assign n_stops   = (stop_cnt_r > 3'(MAX_STOPS)) ? 3'(MAX_STOPS) : stop_cnt_r;
  assign list_mode = (n_stops >= 3'd2);
  always_comb begin
    if (stop_cnt_r == 3'd0) begin
      iv = STOP_W'(DEFAULT_TAB);
    end else if (stops_r[0] == '0) begin
      iv = STOP_W'(1);
    end else begin
      iv = stops_r[0];
    end
  end
  assign iv_t = TW'(iv);

  assign col_e  = TW'(col_r);
  assign t_col  = list_mode ? list_next(col_r, n_stops, stops_r) : rept_r;
  assign t_walk = list_mode ? list_next(walk_c_r, n_stops, stops_r) : walk_t_r;

  // one step of the run walk
  assign c_walk_e  = TW'(walk_c_r);
  assign is_tab    = (t_walk > c_walk_e + TW'(1)) && (t_walk <= col_e);
  assign c_step_e  = is_tab ? t_walk : c_walk_e + TW'(1);
  assign walk_done = (c_step_e >= col_e);

  // item classification
  assign is_blank = (in_byte_r == C_SPACE) || (in_byte_r == C_TAB);
  assign elig     = !in_type_r && is_blank && (all_mode_r || !seen_r);
  assign run_busy = pend_r && (rs_r != col_r);
  assign is_eol   = (in_byte_r == C_LF) || (in_byte_r == C_CR);
  assign is_bs    = (in_byte_r == C_BS);
  assign ovf_item = ovf_r || (!in_type_r && !is_eol && !is_bs && col_r == MAXC);

  // blank absorbed into the pending run
  assign rs_e    = pend_r ? TW'(rs_r) : col_e;
  assign nc0     = (in_byte_r == C_TAB && t_col > col_e) ? t_col : col_e + TW'(1);
  assign nc_ovf1 = (nc0 > MAXC_T);
  assign nc1     = nc_ovf1 ? MAXC_T : nc0;
  assign nc_ovf2 = ((nc1 - rs_e) > MAXP_T);
  assign nc2     = nc_ovf2 ? rs_e + MAXP_T : nc1;

  // restoring remainder steps: col_r mod iv and rs_r mod iv, MSB first
  assign rem_sh    = {rem_r[STOP_W-1:0], col_r[div_cnt_r]};
  assign rem_step  = (rem_sh >= {1'b0, iv}) ? rem_sh - {1'b0, iv} : rem_sh;
  assign rrem_sh   = {rrem_r[STOP_W-1:0], rs_r[div_cnt_r]};
  assign rrem_step = (rrem_sh >= {1'b0, iv}) ? rrem_sh - {1'b0, iv} : rrem_sh;

  // ---------------- control ----------------
  always_comb begin
    st_nxt       = st_r;
    col_nxt      = col_r;
    rs_nxt       = rs_r;
    pend_nxt     = pend_r;
    seen_nxt     = seen_r;
    ovf_nxt      = ovf_r;
    rept_nxt     = rept_r;
    run_rept_nxt = run_rept_r;
    walk_c_nxt   = walk_c_r;
    walk_t_nxt   = walk_t_r;
    div_cnt_nxt  = div_cnt_r;
    rem_nxt      = rem_r;
    rrem_nxt     = rrem_r;
    consume      = 1'b0;
    push         = 1'b0;
    push_d.out_byte = in_byte_r;
    push_d.last     = 1'b1;
    push_d.overflow = ovf_item;

    if (cfg_wr) begin
      st_nxt      = ST_CALC;
      div_cnt_nxt = CNTW'(CW - 1);
      rem_nxt     = '0;
      rrem_nxt    = '0;
    end else begin
      unique case (st_r)
        ST_RUN: begin
          if (in_vld_r) begin
            if (in_type_r) begin
              if (run_busy) begin
                st_nxt     = ST_WALK;
                walk_c_nxt = rs_r;
                walk_t_nxt = run_rept_r;
              end else begin
                consume  = 1'b1;
                col_nxt  = '0;
                rs_nxt   = '0;
                pend_nxt = 1'b0;
                seen_nxt = 1'b0;
                rept_nxt = iv_t;
              end
            end else if (elig) begin
              consume = 1'b1;
              if (!pend_r) begin
                rs_nxt       = col_r;
                run_rept_nxt = rept_r;
                pend_nxt     = 1'b1;
              end
              col_nxt  = nc2[CW-1:0];
              rept_nxt = (nc2 >= rept_r) ? rept_r + iv_t : rept_r;
              if (nc_ovf1 || nc_ovf2) begin
                ovf_nxt = 1'b1;
              end
            end else if (run_busy) begin
              st_nxt     = ST_WALK;
              walk_c_nxt = rs_r;
              walk_t_nxt = run_rept_r;
            end else if (room) begin
              consume  = 1'b1;
              push     = 1'b1;
              pend_nxt = 1'b0;
              ovf_nxt  = 1'b0;
              if (is_eol) begin
                col_nxt  = '0;
                rept_nxt = iv_t;
                seen_nxt = 1'b0;
              end else if (is_bs) begin
                seen_nxt = 1'b1;
                if (col_r != '0) begin
                  col_nxt = col_r - CW'(1);
                  // stepping back across a stop pulls the stop down to col_r
                  if (col_e == rept_r - iv_t) begin
                    rept_nxt = col_e;
                  end
                end
              end else begin
                seen_nxt = 1'b1;
                if (col_r != MAXC) begin
                  col_nxt  = col_r + CW'(1);
                  rept_nxt = ((col_e + TW'(1)) >= rept_r) ? rept_r + iv_t : rept_r;
                end
              end
            end
          end
        end

        ST_WALK: begin
          if (room) begin
            push            = 1'b1;
            push_d.out_byte = is_tab ? C_TAB : C_SPACE;
            push_d.last     = in_type_r && walk_done;
            walk_c_nxt      = c_step_e[CW-1:0];
            walk_t_nxt      = (c_step_e >= walk_t_r) ? walk_t_r + iv_t : walk_t_r;
            if (walk_done) begin
              st_nxt   = ST_RUN;
              pend_nxt = 1'b0;
              if (in_type_r) begin
                consume  = 1'b1;
                ovf_nxt  = 1'b0;
                col_nxt  = '0;
                rs_nxt   = '0;
                seen_nxt = 1'b0;
                rept_nxt = iv_t;
              end
            end
          end
        end

        ST_CALC: begin
          rem_nxt  = rem_step;
          rrem_nxt = rrem_step;
          if (div_cnt_r == '0) begin
            st_nxt       = ST_RUN;
            rept_nxt     = col_e - TW'(rem_step) + iv_t;
            run_rept_nxt = TW'(rs_r) - TW'(rrem_step) + iv_t;
          end else begin
            div_cnt_nxt = div_cnt_r - CNTW'(1);
          end
        end

        default: begin
          st_nxt = ST_RUN;
        end
      endcase
    end
  end

  assign in_ch.ready = !in_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_RUN;
      in_vld_r   <= 1'b0;
      col_r      <= '0;
      rs_r       <= '0;
      pend_r     <= 1'b0;
      seen_r     <= 1'b0;
      ovf_r      <= 1'b0;
      rept_r     <= TW'(DEFAULT_TAB);
      run_rept_r <= TW'(DEFAULT_TAB);
    end else begin
      st_r       <= st_nxt;
      col_r      <= col_nxt;
      rs_r       <= rs_nxt;
      pend_r     <= pend_nxt;
      seen_r     <= seen_nxt;
      ovf_r      <= ovf_nxt;
      rept_r     <= rept_nxt;
      run_rept_r <= run_rept_nxt;
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      in_type_r <= in_ch.req_type;
      in_byte_r <= in_ch.in_byte;
    end
    walk_c_r  <= walk_c_nxt;
    walk_t_r  <= walk_t_nxt;
    div_cnt_r <= div_cnt_nxt;
    rem_r     <= rem_nxt;
    rrem_r    <= rrem_nxt;
  end

  // ---------------- output buffer ----------------
  btc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_d),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (head)
  );

  assign out_ch.out_byte = head.out_byte;
  assign out_ch.last     = head.last;
  assign out_ch.overflow = head.overflow;

  a_walk_has_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK) |-> pend_r) else $error("run walk without pending run");
  a_run_span: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ((col_e - TW'(rs_r)) <= MAXP_T)) else $error("pending run too long");
  a_calc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CALC) |-> !push) else $error("result emitted during stop recompute");
  a_last_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_d.last) |-> consume) else $error("last result without retiring item");

endmodule

[rtl/btc_obuf.sv]
module btc_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  btc_pkg::res_t   push_data,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output btc_pkg::res_t   out_data
);
  import btc_pkg::*;

  // two-entry output buffer: head register plus skid entry
  logic [1:0] cnt_r, cnt_nxt;
  res_t       head_r, head_nxt;
  res_t       skid_r, skid_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;
  assign room      = (cnt_r != 2'd2);

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_data;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          skid_nxt = push_data;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room) else $error("item pushed into full output buffer");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output buffer count out of range");
  a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && pop) |=> head_r == $past(skid_r))
    else $error("skid entry lost on pop");

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import btc_pkg::*;

  localparam int COL_LIMIT   = 4095;
  localparam int RESULT_CAP  = 64;
  localparam int SETTLE      = 24;    // covers the stop rebuild after a write
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic       req_type;
    logic [7:0] text_byte;
  } text_item_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  btc_in_if  in_ch ();
  btc_out_if out_ch ();

  blank_run_to_tab_converter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Converter model: configuration, line state and the bytes it should emit
  // ---------------------------------------------------------------------------
  int unsigned cfg_all;
  int unsigned cfg_nstops;
  int unsigned cfg_stop [NUM_STOPS];

  int unsigned col_now;
  int unsigned run_col0;
  bit          run_open;
  bit          line_started;
  bit          ovf_seen;

  res_t        step_out[$];
  res_t        expected_out[$];
  text_item_t  text_feed[$];

  int          err_count = 0;
  int          items_taken = 0;
  logic        hold_off = 1'b0;

  function automatic int unsigned tab_after(int unsigned c);
    int unsigned n;
    int unsigned iv;
    int unsigned i;
    n = (cfg_nstops > MAX_STOPS) ? MAX_STOPS : cfg_nstops;
    if (n <= 1) begin
      iv = (n == 0) ? DEFAULT_TAB : cfg_stop[0];
      if (iv == 0) iv = 1;
      return (c / iv + 1) * iv;
    end
    for (i = 0; i < n; i++)
      if (cfg_stop[i] > c) return cfg_stop[i];
    return c;   // past the last listed stop
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    if (step_out.size() < RESULT_CAP)
      step_out.push_back('{out_byte: b, last: 1'b0, overflow: 1'b0});
  endfunction

  function automatic void flush_run();
    int unsigned c;
    int unsigned t;
    if (!run_open) return;
    c = run_col0;
    while (c < col_now) begin
      t = tab_after(c);
      if (t > c + 1 && t <= col_now) begin
        emit_byte(C_TAB);
        c = t;
      end else begin
        emit_byte(C_SPACE);
        c++;
      end
    end
    run_open = 1'b0;
  endfunction

  function automatic void unexpand_item(text_item_t it);
    logic [7:0]  b;
    int unsigned nc;
    int unsigned t;
    b = it.text_byte;
    step_out.delete();
    if (it.req_type) begin
      flush_run();
      col_now      = 0;
      run_col0     = 0;
      run_open     = 1'b0;
      line_started = 1'b0;
    end else if ((cfg_all != 0 || !line_started) && (b == C_SPACE || b == C_TAB)) begin
      if (!run_open) begin
        run_col0 = col_now;
        run_open = 1'b1;
      end
      if (b == C_SPACE) begin
        nc = col_now + 1;
      end else begin
        t  = tab_after(col_now);
        nc = (t <= col_now) ? col_now + 1 : t;
      end
      if (nc > COL_LIMIT) begin
        nc = COL_LIMIT;
        ovf_seen = 1'b1;
      end
      if (nc - run_col0 > MAX_PENDING) begin
        nc = run_col0 + MAX_PENDING;
        ovf_seen = 1'b1;
      end
      col_now = nc;
    end else begin
      flush_run();
      emit_byte(b);
      if (b == C_LF || b == C_CR) begin
        col_now = 0;
        line_started = 1'b0;
      end else if (b == C_BS) begin
        if (col_now > 0) col_now--;
        line_started = 1'b1;
      end else begin
        if (col_now >= COL_LIMIT) begin
          col_now = COL_LIMIT;
          ovf_seen = 1'b1;
        end else begin
          col_now++;
        end
        line_started = 1'b1;
      end
    end
    if (step_out.size() > 0) begin
      foreach (step_out[k]) begin
        step_out[k].overflow = ovf_seen;
        step_out[k].last     = (k == step_out.size() - 1);
        expected_out.push_back(step_out[k]);
      end
      ovf_seen = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_text(logic [7:0] b);
    text_feed.push_back('{req_type: 1'b0, text_byte: b});
  endfunction

  function automatic void add_eos();
    text_feed.push_back('{req_type: 1'b1, text_byte: 8'($urandom())});
  endfunction

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) != 0) ? C_SPACE : C_TAB;
  endfunction

  function automatic logic [7:0] pick_glyph();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 92) return C_BS;
    return 8'($urandom_range(0, 255));   // noise, any code
  endfunction

  // Lines of leading blanks, words and blank gaps, then a line end, an end-of-source item or nothing.
  function automatic void add_random_text(int unsigned n_items);
    int unsigned start;
    int unsigned lead;
    int unsigned words;
    int unsigned len;
    int unsigned r;
    start = text_feed.size();
    while (text_feed.size() - start < n_items) begin
      lead = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      repeat (lead) add_text(pick_blank());
      words = $urandom_range(0, 4);
      repeat (words) begin
        len = $urandom_range(1, 6);
        repeat (len) add_text(pick_glyph());
        repeat ($urandom_range(0, 3)) add_text(pick_blank());
      end
      r = $urandom_range(0, 99);
      if (r < 70)
        add_text(C_LF);
      else if (r < 85)
        add_text(C_CR);
      else if (r < 93)
        add_eos();
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (text_feed.size() != 0 || in_ch.valid || expected_out.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned n_items);
    @(negedge clk);
    add_random_text(n_items);
    wait_drained();
  endtask

  // Register write; bits above the field width carry junk.
  task automatic set_reg(logic [2:0] idx, int unsigned value);
    logic [31:0] mask;
    logic [31:0] word;
    case (idx)
      REG_ALL_MODE: mask = 32'h1;
      REG_STOP_CNT: mask = 32'h7;
      default:      mask = 32'hFFF;
    endcase
    word = (value & mask) | ($urandom() & ~mask);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ALL_MODE: cfg_all    = word & 32'h1;
      REG_STOP_CNT: cfg_nstops = word & 32'h7;
      default:      cfg_stop[idx - REG_STOP_A] = word & 32'hFFF;
    endcase
  endtask

  task automatic set_stops(int unsigned s0, int unsigned s1, int unsigned s2,
                           int unsigned s3, int unsigned s4, int unsigned s5);
    int unsigned vals [NUM_STOPS];
    vals = '{s0, s1, s2, s3, s4, s5};
    for (int i = 0; i < NUM_STOPS; i++)
      set_reg(3'(REG_STOP_A + i), vals[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of items from text_feed with random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : drive_in
    text_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        unexpand_item('{req_type: in_ch.req_type, text_byte: in_ch.in_byte});
        items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (text_feed.size() > 0) begin
          it = text_feed.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.req_type <= it.req_type;
          in_ch.in_byte  <= it.text_byte;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: ready pattern picked at random from four modes, results checked in order
  // ---------------------------------------------------------------------------
  int unsigned stall_tick = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk) begin : watch_out
    logic pat;
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_out.size() == 0) begin
          $error("unexpected result: out_byte %02h last %0b overflow %0b",
                 out_ch.out_byte, out_ch.last, out_ch.overflow);
          err_count++;
        end else begin
          want = expected_out.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_ch.out_byte);
            err_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            err_count++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_ch.overflow);
            err_count++;
          end
        end
      end
      stall_tick++;
      if (stall_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       pat = 1'b1;
        1:       pat = ($urandom_range(0, 1) != 0);
        2:       pat = (stall_tick % 4 != 0);
        default: pat = ($urandom_range(0, 4) == 0);
      endcase
      out_ch.ready <= !hold_off && pat;
    end
  end

  // Long receiver hold-off while the sender keeps offering items
  initial begin
    @(posedge clk);
    while (!(text_feed.size() > 40 && items_taken > 120)) @(negedge clk);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: cycles without any handshake or register access
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** blank_run_to_tab_converter: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;

    cfg_all    = 0;
    cfg_nstops = 0;
    for (int i = 0; i < NUM_STOPS; i++) cfg_stop[i] = 8 * (i + 1);
    col_now      = 0;
    run_col0     = 0;
    run_open     = 1'b0;
    line_started = 1'b0;
    ovf_seen     = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset configuration: stops every 8, line start only
    @(negedge clk);
    add_text(C_SPACE); add_text(C_SPACE); add_text(C_TAB); add_text("a");  // run to a stop
    add_text(C_SPACE); add_text(C_TAB);                                    // after nonblank
    add_text(C_BS); add_text(C_LF);
    add_text(C_SPACE); add_text(C_CR);                                     // single column
    add_text(8'hFF); add_text(8'h00); add_text(C_LF);
    add_eos();                                                             // nothing pending
    add_text(C_SPACE); add_text(C_SPACE); add_text(C_SPACE); add_eos();    // flush on end
    add_text(C_BS);                                                        // column already 0
    add_text(C_TAB); add_text(C_TAB); add_text("x");
    add_text(C_SPACE); add_text(C_SPACE); add_text(C_SPACE); add_text(C_SPACE);
    add_text(C_SPACE); add_text("y"); add_text(C_CR);
    wait_drained();

    // repeating stop every 4, blanks anywhere
    set_reg(REG_ALL_MODE, 1);
    set_reg(REG_STOP_CNT, 1);
    set_reg(REG_STOP_A, 4);
    random_phase(40);

    // short explicit list, line start only
    set_reg(REG_ALL_MODE, 0);
    set_reg(REG_STOP_CNT, 3);
    set_stops(3, 9, 20, 32, 40, 48);
    random_phase(40);

    // full list ending on the largest column
    set_reg(REG_ALL_MODE, 1);
    set_reg(REG_STOP_CNT, 6);
    set_stops(2, 5, 11, 17, 30, 4095);
    random_phase(40);

    // count above the list size acts as the full list
    set_reg(REG_ALL_MODE, 0);
    set_reg(REG_STOP_CNT, 7);
    set_stops(1, 7, 13, 14, 50, 4094);
    random_phase(40);

    // zero repeat interval acts as one
    set_reg(REG_ALL_MODE, 1);
    set_reg(REG_STOP_CNT, 1);
    set_reg(REG_STOP_A, 0);
    random_phase(40);

    set_reg(REG_ALL_MODE, 0);
    set_reg(REG_STOP_A, 1);
    random_phase(30);

    // saturation: tab runs clamp at the pending limit while the column walks to the max
    set_reg(REG_ALL_MODE, 1);
    set_reg(REG_STOP_A, 4095);
    @(negedge clk);
    repeat (64) begin
      add_text(C_TAB);
      add_text("x");
    end
    add_text(C_SPACE); add_text(C_SPACE); add_text("z"); add_text("q");
    add_text(C_LF);
    wait_drained();

    // list whose stops sit at the max column
    set_reg(REG_STOP_CNT, 2);
    set_stops(4095, 4095, 24, 32, 40, 48);
    random_phase(40);

    // back to default stops
    set_reg(REG_ALL_MODE, 0);
    set_reg(REG_STOP_CNT, 0);
    random_phase(40);

    if (err_count == 0 && expected_out.size() == 0) begin
      $display("** blank_run_to_tab_converter: PASSED **");
    end else begin
      $display("** blank_run_to_tab_converter: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/btc_pkg.sv
rtl/btc_in_if.sv
rtl/btc_out_if.sv
rtl/btc_obuf.sv
rtl/blank_run_to_tab_converter.sv
tb/sv/testbench.sv
